[rtl/cfa_pkg.sv]
// Package for the Coulomb field accumulator: operation and status codes,
// sequencer states and default sizes. No dependencies.
`default_nettype none
package cfa_pkg;

    localparam int MAX_CHARGES_DEF = 64;

    localparam logic [2:0] FUNC_APPEND = 3'd0;
    localparam logic [2:0] FUNC_REMOVE = 3'd1;
    localparam logic [2:0] FUNC_FIELD  = 3'd2;
    localparam logic [2:0] FUNC_FORCE  = 3'd3;
    localparam logic [2:0] FUNC_SELF   = 3'd4;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_EMPTY      = 3'd1,
        ST_COINCIDENT = 3'd2,
        ST_BAD_INDEX  = 3'd3,
        ST_FULL       = 3'd4,
        ST_ZERO       = 3'd5
    } status_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_APPEND,
        S_RM_RD,
        S_RM_WR,
        S_SELF_RD,
        S_SELF_LD,
        S_CH_RD,
        S_CH_LD,
        S_R2,
        S_R2_CHK,
        S_TERM_MUL,
        S_TERM_DIV,
        S_TERM_ADD,
        S_E2,
        S_EM_CHK,
        S_MAG_K,
        S_MAG_SET,
        S_DIR,
        S_DIR_SET,
        S_DONE,
        S_MUL,
        S_SQRT,
        S_DIV
    } state_t;

    localparam logic signed [63:0] ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic [47:0] MAG_MAX = 48'hFFFF_FFFF_FFFF;

endpackage
`default_nettype wire

[rtl/coulomb_field_accumulator.sv]
// Coulomb field accumulator: charge store, sequencer and shared multiply,
// square root and divide units. Depends on cfa_pkg.
// An error status or unknown func goes straight to done; append writes one entry,
// remove moves each later entry down one place. A query walks the stored charges;
// force on a stored charge first reads that charge and then skips it in the walk.
// The divider is bit-serial.
// One item at a time; busy stays high through the done strobe. The strobe
// cannot be stalled. Reset empties the store and sets the constant to 1.0.
`default_nettype none
module coulomb_field_accumulator #(
    parameter int MAX_CHARGES = cfa_pkg::MAX_CHARGES_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [2:0]         func,
    input  wire logic signed [31:0] pos_x,
    input  wire logic signed [31:0] pos_y,
    input  wire logic signed [31:0] pos_z,
    input  wire logic signed [31:0] charge_value,
    input  wire logic [5:0]         charge_index,
    input  wire logic               cfg_we,
    input  wire logic [31:0]        cfg_data,
    output logic                    done,
    output logic [2:0]              status,
    output logic [47:0]             magnitude,
    output logic signed [17:0]      dir_x,
    output logic signed [17:0]      dir_y,
    output logic signed [17:0]      dir_z
);
    import cfa_pkg::*;

    localparam int CNT_W = $clog2(MAX_CHARGES + 1);
    localparam int IDX_W = (MAX_CHARGES > 1) ? $clog2(MAX_CHARGES) : 1;
    localparam int CMP_W = (CNT_W > 6) ? CNT_W : 6;

    logic [127:0] mem [MAX_CHARGES];
    logic [127:0] rdata_reg;
    logic [IDX_W-1:0] rd_addr, wr_addr;
    logic [127:0] wr_data;
    logic mem_we;

    state_t state_reg, state_next, ret_reg, ret_next;
    logic [CNT_W-1:0] count_reg, count_next, j_reg, j_next;
    logic [31:0] k_reg, k_next;
    logic force_reg, force_next, skip_reg, skip_next;
    logic [5:0] idx_reg, idx_next;
    logic [1:0] comp_reg, comp_next, pass_reg, pass_next;
    logic [6:0] ucnt_reg, ucnt_next;
    logic [31:0] p_reg [3], p_next [3];
    logic [31:0] qv_reg, qv_next, aqt_reg, aqt_next, aq_reg, aq_next;
    logic qtneg_reg, qtneg_next, qneg_reg, qneg_next;
    logic [31:0] ad_reg [3], ad_next [3];
    logic dneg_reg [3], dneg_next [3];
    logic signed [63:0] e_reg [3], e_next [3];
    logic [127:0] acc_reg, acc_next, opa_reg, opa_next;
    logic [63:0] opb_reg, opb_next, pp_reg, pp_next;
    logic [127:0] q_reg, q_next, sx_reg, sx_next;
    logic [63:0] rem_reg, rem_next, dd_reg, dd_next, root_reg, root_next;
    logic [65:0] srem_reg, srem_next;
    status_t status_reg, status_next;
    logic [47:0] mag_reg, mag_next;
    logic [17:0] dir_reg [3], dir_next [3];

    logic [CMP_W-1:0] idx_c, count_c, j_c, in_idx_c;
    logic [31:0] ka_chunk, kb_chunk;
    logic [2:0] sh_sum;
    logic [127:0] pp_shift;
    logic [67:0] s_sh, s_trial;
    logic [64:0] d_sh;
    logic [32:0] dsub [3];
    logic [63:0] m_sat, e_abs, e_pos;
    logic signed [64:0] s_sum;
    logic signed [63:0] c_term;
    logic [79:0] mag_src;
    logic [17:0] dir_v;
    logic [CNT_W:0] j_inc;

    assign busy      = (state_reg != S_IDLE);
    assign done      = (state_reg == S_DONE);
    assign status    = status_reg;
    assign magnitude = mag_reg;
    assign dir_x     = dir_reg[0];
    assign dir_y     = dir_reg[1];
    assign dir_z     = dir_reg[2];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
            count_reg <= '0;
            k_reg     <= 32'd65536;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            count_reg <= count_next;
            k_reg     <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        j_reg      <= j_next;
        force_reg  <= force_next;
        skip_reg   <= skip_next;
        idx_reg    <= idx_next;
        comp_reg   <= comp_next;
        pass_reg   <= pass_next;
        ucnt_reg   <= ucnt_next;
        qv_reg     <= qv_next;
        aqt_reg    <= aqt_next;
        aq_reg     <= aq_next;
        qtneg_reg  <= qtneg_next;
        qneg_reg   <= qneg_next;
        acc_reg    <= acc_next;
        opa_reg    <= opa_next;
        opb_reg    <= opb_next;
        pp_reg     <= pp_next;
        q_reg      <= q_next;
        sx_reg     <= sx_next;
        rem_reg    <= rem_next;
        dd_reg     <= dd_next;
        root_reg   <= root_next;
        srem_reg   <= srem_next;
        status_reg <= status_next;
        mag_reg    <= mag_next;
        for (int i = 0; i < 3; i++)
        begin
            p_reg[i]    <= p_next[i];
            ad_reg[i]   <= ad_next[i];
            dneg_reg[i] <= dneg_next[i];
            e_reg[i]    <= e_next[i];
            dir_reg[i]  <= dir_next[i];
        end
    end

    assign idx_c    = CMP_W'(idx_reg);
    assign in_idx_c = CMP_W'(charge_index);
    assign count_c  = CMP_W'(count_reg);
    assign j_c      = CMP_W'(j_reg);
    assign j_inc    = {1'b0, j_reg} + 1'b1;

    assign ka_chunk = opa_reg[32*ucnt_reg[2:1] +: 32];
    assign kb_chunk = opb_reg[32*ucnt_reg[3] +: 32];
    assign sh_sum   = {1'b0, ucnt_reg[2:1]} + {2'b00, ucnt_reg[3]};
    assign pp_shift = {64'd0, pp_reg} << {sh_sum, 5'b00000};
    assign s_sh     = {srem_reg, sx_reg[127:126]};
    assign s_trial  = {2'b00, root_reg, 2'b01};
    assign d_sh     = {rem_reg, q_reg[127]};

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dsub[i] = {p_reg[i][31], p_reg[i]} - {rdata_reg[32*i+31], rdata_reg[32*i +: 32]};
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        ret_next    = ret_reg;
        count_next  = count_reg;
        k_next      = k_reg;
        j_next      = j_reg;
        force_next  = force_reg;
        skip_next   = skip_reg;
        idx_next    = idx_reg;
        comp_next   = comp_reg;
        pass_next   = pass_reg;
        ucnt_next   = ucnt_reg;
        qv_next     = qv_reg;
        aqt_next    = aqt_reg;
        aq_next     = aq_reg;
        qtneg_next  = qtneg_reg;
        qneg_next   = qneg_reg;
        acc_next    = acc_reg;
        opa_next    = opa_reg;
        opb_next    = opb_reg;
        pp_next     = pp_reg;
        q_next      = q_reg;
        sx_next     = sx_reg;
        rem_next    = rem_reg;
        dd_next     = dd_reg;
        root_next   = root_reg;
        srem_next   = srem_reg;
        status_next = status_reg;
        mag_next    = mag_reg;
        p_next      = p_reg;
        ad_next     = ad_reg;
        dneg_next   = dneg_reg;
        e_next      = e_reg;
        dir_next    = dir_reg;
        mem_we      = 1'b0;
        wr_addr     = IDX_W'(count_reg);
        wr_data     = {qv_reg, p_reg[2], p_reg[1], p_reg[0]};
        rd_addr     = IDX_W'(j_reg);
        m_sat       = '0;
        e_abs       = '0;
        e_pos       = '0;
        s_sum       = '0;
        c_term      = '0;
        mag_src     = '0;
        dir_v       = '0;

        if (cfg_we)
        begin
            k_next = cfg_data;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    idx_next    = charge_index;
                    p_next[0]   = pos_x;
                    p_next[1]   = pos_y;
                    p_next[2]   = pos_z;
                    qv_next     = charge_value;
                    aqt_next    = charge_value[31] ? 32'(-charge_value) : charge_value;
                    qtneg_next  = charge_value[31];
                    force_next  = (func == FUNC_FORCE) || (func == FUNC_SELF);
                    skip_next   = (func == FUNC_SELF);
                    status_next = ST_OK;
                    mag_next    = '0;
                    for (int i = 0; i < 3; i++)
                    begin
                        dir_next[i] = '0;
                        e_next[i]   = '0;
                    end
                    j_next     = '0;
                    state_next = S_DONE;
                    unique case (func) inside
                        FUNC_APPEND:
                        begin
                            if (count_reg == CNT_W'(MAX_CHARGES))
                                status_next = ST_FULL;
                            else
                                state_next = S_APPEND;
                        end
                        FUNC_REMOVE:
                        begin
                            if (in_idx_c >= count_c)
                                status_next = ST_BAD_INDEX;
                            else
                            begin
                                j_next     = CNT_W'(charge_index);
                                state_next = S_RM_RD;
                            end
                        end
                        FUNC_FIELD, FUNC_FORCE:
                        begin
                            if (count_reg == '0)
                                status_next = ST_EMPTY;
                            else
                                state_next = S_CH_RD;
                        end
                        FUNC_SELF:
                        begin
                            if (count_reg == '0)
                                status_next = ST_EMPTY;
                            else if (in_idx_c >= count_c)
                                status_next = ST_BAD_INDEX;
                            else
                                state_next = S_SELF_RD;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_APPEND:
            begin
                mem_we     = 1'b1;
                count_next = count_reg + 1'b1;
                state_next = S_DONE;
            end

            S_RM_RD:
            begin
                if (j_inc >= {1'b0, count_reg})
                begin
                    count_next = count_reg - 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    rd_addr    = IDX_W'(j_inc);
                    state_next = S_RM_WR;
                end
            end

            S_RM_WR:
            begin
                mem_we     = 1'b1;
                wr_addr    = IDX_W'(j_reg);
                wr_data    = rdata_reg;
                j_next     = CNT_W'(j_inc);
                state_next = S_RM_RD;
            end

            S_SELF_RD:
            begin
                rd_addr    = IDX_W'(idx_c);
                state_next = S_SELF_LD;
            end

            S_SELF_LD:
            begin
                p_next[0]  = rdata_reg[31:0];
                p_next[1]  = rdata_reg[63:32];
                p_next[2]  = rdata_reg[95:64];
                aqt_next   = rdata_reg[127] ? 32'(-rdata_reg[127:96]) : rdata_reg[127:96];
                qtneg_next = rdata_reg[127];
                state_next = S_CH_RD;
            end

            S_CH_RD:
            begin
                if (j_reg == count_reg)
                begin
                    acc_next   = '0;
                    comp_next  = '0;
                    state_next = S_E2;
                end
                else if (skip_reg && (j_c == idx_c))
                begin
                    j_next = CNT_W'(j_inc);
                end
                else
                begin
                    rd_addr    = IDX_W'(j_reg);
                    state_next = S_CH_LD;
                end
            end

            S_CH_LD:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    dneg_next[i] = dsub[i][32];
                    ad_next[i]   = dsub[i][32] ? 32'(-dsub[i]) : dsub[i][31:0];
                end
                qneg_next  = rdata_reg[127];
                aq_next    = rdata_reg[127] ? 32'(-rdata_reg[127:96]) : rdata_reg[127:96];
                acc_next   = '0;
                comp_next  = '0;
                state_next = S_R2;
            end

            S_R2:
            begin
                if (comp_reg == 2'd3)
                begin
                    state_next = S_R2_CHK;
                end
                else
                begin
                    opa_next   = 128'(ad_reg[comp_reg]);
                    opb_next   = 64'(ad_reg[comp_reg]);
                    comp_next  = comp_reg + 1'b1;
                    ucnt_next  = '0;
                    ret_next   = S_R2;
                    state_next = S_MUL;
                end
            end

            S_R2_CHK:
            begin
                if (acc_reg == '0)
                begin
                    if (force_reg)
                    begin
                        status_next = ST_COINCIDENT;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        j_next     = CNT_W'(j_inc);
                        state_next = S_CH_RD;
                    end
                end
                else
                begin
                    sx_next    = acc_reg;
                    srem_next  = '0;
                    root_next  = '0;
                    ucnt_next  = '0;
                    comp_next  = '0;
                    ret_next   = S_TERM_MUL;
                    state_next = S_SQRT;
                end
            end

            S_TERM_MUL:
            begin
                if (comp_reg == 2'd3)
                begin
                    j_next     = CNT_W'(j_inc);
                    state_next = S_CH_RD;
                end
                else
                begin
                    opa_next   = 128'(aq_reg);
                    opb_next   = 64'(ad_reg[comp_reg]);
                    acc_next   = '0;
                    pass_next  = '0;
                    ucnt_next  = '0;
                    ret_next   = S_TERM_DIV;
                    state_next = S_MUL;
                end
            end

            S_TERM_DIV:
            begin
                if (pass_reg == 2'd3)
                begin
                    state_next = S_TERM_ADD;
                end
                else
                begin
                    if (pass_reg == 2'd0)
                        q_next = acc_reg << 48;
                    rem_next   = '0;
                    dd_next    = root_reg;
                    pass_next  = pass_reg + 1'b1;
                    ucnt_next  = '0;
                    ret_next   = S_TERM_DIV;
                    state_next = S_DIV;
                end
            end

            S_TERM_ADD:
            begin
                m_sat  = (q_reg[127:63] != '0) ? 64'(ACC_MAX) : {1'b0, q_reg[62:0]};
                c_term = (qneg_reg != dneg_reg[comp_reg]) ? -$signed(m_sat) : $signed(m_sat);
                s_sum  = 65'(e_reg[comp_reg]) + 65'(c_term);
                if (s_sum > 65'(ACC_MAX))
                    e_next[comp_reg] = ACC_MAX;
                else if (s_sum < -65'(ACC_MAX))
                    e_next[comp_reg] = -ACC_MAX;
                else
                    e_next[comp_reg] = s_sum[63:0];
                comp_next  = comp_reg + 1'b1;
                state_next = S_TERM_MUL;
            end

            S_E2:
            begin
                if (comp_reg == 2'd3)
                begin
                    sx_next    = acc_reg;
                    srem_next  = '0;
                    root_next  = '0;
                    ucnt_next  = '0;
                    ret_next   = S_EM_CHK;
                    state_next = S_SQRT;
                end
                else
                begin
                    e_abs      = e_reg[comp_reg][63] ? 64'(-e_reg[comp_reg]) : e_reg[comp_reg];
                    opa_next   = 128'(e_abs);
                    opb_next   = e_abs;
                    comp_next  = comp_reg + 1'b1;
                    ucnt_next  = '0;
                    ret_next   = S_E2;
                    state_next = S_MUL;
                end
            end

            S_EM_CHK:
            begin
                if ((root_reg == '0) || (k_reg == '0) || (force_reg && (aqt_reg == '0)))
                begin
                    status_next = ST_ZERO;
                    state_next  = S_DONE;
                end
                else
                begin
                    opa_next   = 128'(root_reg);
                    opb_next   = 64'(k_reg);
                    acc_next   = '0;
                    ucnt_next  = '0;
                    ret_next   = S_MAG_K;
                    state_next = S_MUL;
                end
            end

            S_MAG_K:
            begin
                if (force_reg)
                begin
                    opa_next   = acc_reg;
                    opb_next   = 64'(aqt_reg);
                    acc_next   = '0;
                    ucnt_next  = '0;
                    ret_next   = S_MAG_SET;
                    state_next = S_MUL;
                end
                else
                begin
                    state_next = S_MAG_SET;
                end
            end

            S_MAG_SET:
            begin
                if (force_reg)
                begin
                    mag_src  = acc_reg[127:48];
                    mag_next = (mag_src[79:48] != '0) ? MAG_MAX : mag_src[47:0];
                end
                else
                begin
                    mag_next = (acc_reg[127:80] != '0) ? MAG_MAX : acc_reg[79:32];
                end
                comp_next  = '0;
                state_next = S_DIR;
            end

            S_DIR:
            begin
                if (comp_reg == 2'd3)
                begin
                    status_next = ST_OK;
                    state_next  = S_DONE;
                end
                else
                begin
                    e_abs      = e_reg[comp_reg][63] ? 64'(-e_reg[comp_reg]) : e_reg[comp_reg];
                    q_next     = {48'd0, e_abs, 16'd0};
                    rem_next   = '0;
                    dd_next    = root_reg;
                    ucnt_next  = '0;
                    ret_next   = S_DIR_SET;
                    state_next = S_DIV;
                end
            end

            S_DIR_SET:
            begin
                e_pos = q_reg[63:0];
                dir_v = e_pos[17:0];
                if (e_reg[comp_reg][63] != (force_reg && qtneg_reg))
                    dir_next[comp_reg] = 18'(-dir_v);
                else
                    dir_next[comp_reg] = dir_v;
                comp_next  = comp_reg + 1'b1;
                state_next = S_DIR;
            end

            S_DONE:
            begin
                state_next = S_IDLE;
            end

            S_MUL:
            begin
                if (!ucnt_reg[0])
                    pp_next = ka_chunk * kb_chunk;
                else
                    acc_next = acc_reg + pp_shift;
                ucnt_next = ucnt_reg + 1'b1;
                if (ucnt_reg == 7'd15)
                    state_next = ret_reg;
            end

            S_SQRT:
            begin
                if (s_sh >= s_trial)
                begin
                    srem_next = 66'(s_sh - s_trial);
                    root_next = {root_reg[62:0], 1'b1};
                end
                else
                begin
                    srem_next = s_sh[65:0];
                    root_next = {root_reg[62:0], 1'b0};
                end
                sx_next   = sx_reg << 2;
                ucnt_next = ucnt_reg + 1'b1;
                if (ucnt_reg == 7'd63)
                    state_next = ret_reg;
            end

            S_DIV:
            begin
                if (d_sh >= {1'b0, dd_reg})
                begin
                    rem_next = 64'(d_sh - {1'b0, dd_reg});
                    q_next   = {q_reg[126:0], 1'b1};
                end
                else
                begin
                    rem_next = d_sh[63:0];
                    q_next   = {q_reg[126:0], 1'b0};
                end
                ucnt_next = ucnt_reg + 1'b1;
                if (ucnt_reg == 7'd127)
                    state_next = ret_reg;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire
